>>> rtl/accumulator_vm_execute_assert.svh
// Assertion macros for the checker file of the accumulator machine.
`ifndef ACCUMULATOR_VM_EXECUTE_ASSERT_SVH
`define ACCUMULATOR_VM_EXECUTE_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define AVM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("accumulator_vm_execute check failed");

// Next-cycle implication, ignored while reset is high.
`define AVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("accumulator_vm_execute check failed");

`endif

>>> rtl/avm_pkg.sv
// Package: beat types, machine state type and opcode codes of the accumulator machine.
package avm_pkg;

   typedef logic [4:0] opcode_type;

   localparam opcode_type OP_NOP  = 5'd0;
   localparam opcode_type OP_LDI  = 5'd1;
   localparam opcode_type OP_RSV2 = 5'd2;
   localparam opcode_type OP_LD   = 5'd3;
   localparam opcode_type OP_RSV4 = 5'd4;
   localparam opcode_type OP_ST   = 5'd5;
   localparam opcode_type OP_LT   = 5'd6;
   localparam opcode_type OP_GT   = 5'd7;
   localparam opcode_type OP_EQI  = 5'd8;
   localparam opcode_type OP_EQ   = 5'd9;
   localparam opcode_type OP_BZ   = 5'd10;
   localparam opcode_type OP_BNZ  = 5'd11;
   localparam opcode_type OP_DLY  = 5'd12;
   localparam opcode_type OP_RSV13 = 5'd13;
   localparam opcode_type OP_LTE  = 5'd14;
   localparam opcode_type OP_GTE  = 5'd15;
   localparam opcode_type OP_HALT = 5'd16;
   localparam opcode_type OP_JMP  = 5'd17;
   localparam opcode_type OP_ADDI = 5'd18;
   localparam opcode_type OP_ADD  = 5'd19;
   localparam opcode_type OP_SUBI = 5'd20;
   localparam opcode_type OP_SUB  = 5'd21;

   typedef struct packed {
      opcode_type         opcode;
      logic signed [31:0] immediate;
      logic signed [31:0] io_value;
      logic               io_is_message;
   } req_type;

   typedef struct packed {
      logic [7:0]         next_pc;
      logic signed [31:0] acc_out;
      logic               halted;
      logic               store_request;
      logic               message_request;
      logic               delay_request;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] accumulator;
      logic signed [31:0] operand_register;
      logic [7:0]         program_counter;
      logic               halt_flag;
   } state_type;

endpackage

>>> rtl/avm_exec.sv
// Execute logic: one instruction applied to the machine state, purely combinational.
module avm_exec (
   input  avm_pkg::state_type state_cur,
   input  avm_pkg::req_type   instr,
   output avm_pkg::state_type state_nxt,
   output avm_pkg::rsp_type   result
);

   logic signed [31:0] opnd;
   logic signed [31:0] acc;
   logic [7:0]         pc_inc;
   logic [7:0]         target;

   assign acc    = state_cur.accumulator;
   assign pc_inc = state_cur.program_counter + 8'd1;
   assign target = instr.immediate[7:0];

   // Load the operand register first; every reader uses the fresh value.
   always_comb begin
      unique case (instr.opcode)
         avm_pkg::OP_LDI, avm_pkg::OP_EQI, avm_pkg::OP_DLY,
         avm_pkg::OP_ADDI, avm_pkg::OP_SUBI: begin
            opnd = instr.immediate;
         end
         avm_pkg::OP_LD, avm_pkg::OP_LT, avm_pkg::OP_GT, avm_pkg::OP_EQ,
         avm_pkg::OP_LTE, avm_pkg::OP_GTE, avm_pkg::OP_ADD, avm_pkg::OP_SUB: begin
            opnd = instr.io_value;
         end
         default: begin
            opnd = state_cur.operand_register;
         end
      endcase
   end

   always_comb begin
      state_nxt                  = state_cur;
      state_nxt.operand_register = opnd;
      state_nxt.program_counter  = pc_inc;
      result.store_request       = 1'b0;
      result.message_request     = 1'b0;
      result.delay_request       = 1'b0;
      unique case (instr.opcode)
         avm_pkg::OP_NOP: begin
         end
         avm_pkg::OP_LDI, avm_pkg::OP_LD: begin
            state_nxt.accumulator = opnd;
         end
         avm_pkg::OP_ST: begin
            result.message_request = instr.io_is_message;
            result.store_request   = ~instr.io_is_message;
         end
         avm_pkg::OP_LT:  state_nxt.accumulator = {31'd0, acc < opnd};
         avm_pkg::OP_GT:  state_nxt.accumulator = {31'd0, acc > opnd};
         avm_pkg::OP_LTE: state_nxt.accumulator = {31'd0, acc <= opnd};
         avm_pkg::OP_GTE: state_nxt.accumulator = {31'd0, acc >= opnd};
         avm_pkg::OP_EQI, avm_pkg::OP_EQ: begin
            state_nxt.accumulator = {31'd0, acc == opnd};
         end
         avm_pkg::OP_BZ: begin
            state_nxt.program_counter = (acc == 32'sd0) ? target : pc_inc;
         end
         avm_pkg::OP_BNZ: begin
            state_nxt.program_counter = (acc != 32'sd0) ? target : pc_inc;
         end
         avm_pkg::OP_DLY: result.delay_request = 1'b1;
         avm_pkg::OP_JMP: state_nxt.program_counter = target;
         avm_pkg::OP_ADDI, avm_pkg::OP_ADD: state_nxt.accumulator = acc + opnd;
         avm_pkg::OP_SUBI, avm_pkg::OP_SUB: state_nxt.accumulator = acc - opnd;
         avm_pkg::OP_RSV2, avm_pkg::OP_RSV4, avm_pkg::OP_RSV13: begin
            state_nxt.program_counter = state_cur.program_counter;
         end
         default: begin
            // halt and every code past the table
            state_nxt.halt_flag       = 1'b1;
            state_nxt.program_counter = state_cur.program_counter;
         end
      endcase
      result.next_pc = state_nxt.program_counter;
      result.acc_out = state_nxt.accumulator;
      result.halted  = state_nxt.halt_flag;
   end

endmodule

>>> rtl/accumulator_vm_execute.sv
// Top level of the accumulator machine execute block: input register, execute, result register.
//
//   channel | direction | payload           | beat
//   --------+-----------+-------------------+----------------------------------
//   req_    | in        | avm_pkg::req_type | one instruction
//   rsp_    | out       | avm_pkg::rsp_type | machine state and requests after it
//
// An instruction reaches rsp_valid through the input and the result register: its req_ beat
// loads the input register, and a later advance executes it into the result register. One beat per
// cycle sustained while rsp_ready holds; the accumulator, pc and halt feedback closes in the execute step.
// Synchronous reset clears the valid bits and the machine state to zero.
// A stalled rsp_ holds the result register, which holds the input register, which
// drops req_ready; nothing is lost or repeated.
module accumulator_vm_execute (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  avm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output avm_pkg::rsp_type rsp_data
);

   logic               in_valid_ff;
   logic               in_valid_in;
   avm_pkg::req_type   in_data_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   avm_pkg::rsp_type   out_data_ff;
   avm_pkg::state_type state_ff;
   avm_pkg::state_type state_in;
   avm_pkg::rsp_type   exec_result;
   logic               advance;
   logic               take;

   // Execute the held instruction when the result register is free or draining.
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign take      = req_valid & req_ready;

   avm_exec u_exec (
      .state_cur (state_ff),
      .instr     (in_data_ff),
      .state_nxt (state_in),
      .result    (exec_result)
   );

   always_comb begin
      in_valid_in = take | (in_valid_ff & ~advance);
      out_valid_in = advance | (out_valid_ff & ~rsp_ready);
   end

   // Control state and machine state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers: capture on a beat, hold otherwise.
   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= exec_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

>>> rtl/avm_checker.sv
// Port checker for the accumulator machine execute block, bound to the top level.
`include "accumulator_vm_execute_assert.svh"

module avm_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input avm_pkg::rsp_type rsp_data
);

   logic       stalled;
   logic       halt_shown;
   logic [2:0] request_flags;

   assign stalled       = rsp_valid && !rsp_ready;
   assign halt_shown    = rsp_valid && rsp_data.halted;
   assign request_flags = {rsp_data.store_request, rsp_data.message_request,
                           rsp_data.delay_request};

   // A stalled result keeps its beat.
   `AVM_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid && $stable(rsp_data))

   // At most one request flag per result.
   `AVM_ASSERT_SAME(a_one_request, clock, reset, rsp_valid, $onehot0(request_flags))

   // Halt stays set on every later result.
   `AVM_ASSERT_NEXT(a_halt_sticky, clock, reset, halt_shown, !rsp_valid || rsp_data.halted)

endmodule

bind accumulator_vm_execute avm_checker u_avm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/tb_accumulator_vm_execute.sv
// Testbench for accumulator_vm_execute: random and directed instructions checked against a local model.
module tb_accumulator_vm_execute;

   localparam int IDLE_LIMIT = 1000;   // cycles with no beat on either channel
   localparam int HOLD_OFF   = 80;     // long receiver stall, well beyond the pipeline depth
   localparam int TAIL_WAIT  = 10;

   // Codes past the table: the first one and the last one.
   localparam avm_pkg::opcode_type OP_PAST_TABLE = 5'd22;
   localparam avm_pkg::opcode_type OP_TOP_CODE   = 5'd31;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   avm_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   avm_pkg::rsp_type rsp_data;

   // Instructions waiting to be offered, and machine states predicted for accepted ones.
   avm_pkg::req_type instr_q[$];
   avm_pkg::rsp_type expected_rsp_q[$];

   // Machine state as the model sees it.
   logic signed [31:0] mach_acc = '0;
   logic signed [31:0] mach_operand = '0;
   logic [7:0]         mach_pc = '0;
   logic               mach_halt = 1'b0;

   int  mismatch_count = 0;
   bit  steady_flow = 1'b0;   // no idling on either side while set
   int  stall_token = 0;      // bump to request one long receiver hold-off
   int  stall_seen = 0;
   int  hold_left = 0;
   int  idle_cycles = 0;

   accumulator_vm_execute u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Execute one instruction on the model state and return the machine state after it.
   function automatic avm_pkg::rsp_type execute_instr(avm_pkg::req_type r);
      avm_pkg::rsp_type o;
      logic [7:0]       pc_inc;
      o = '0;
      pc_inc = mach_pc + 8'd1;
      // Operand register load comes first; the operation then sees the new value.
      case (r.opcode)
         avm_pkg::OP_LDI, avm_pkg::OP_EQI, avm_pkg::OP_DLY, avm_pkg::OP_ADDI,
         avm_pkg::OP_SUBI:
            mach_operand = r.immediate;
         avm_pkg::OP_LD, avm_pkg::OP_LT, avm_pkg::OP_GT, avm_pkg::OP_EQ,
         avm_pkg::OP_LTE, avm_pkg::OP_GTE, avm_pkg::OP_ADD, avm_pkg::OP_SUB:
            mach_operand = r.io_value;
         default: ;
      endcase
      case (r.opcode)
         avm_pkg::OP_NOP: mach_pc = pc_inc;
         avm_pkg::OP_LDI, avm_pkg::OP_LD: begin
            mach_acc = mach_operand;
            mach_pc = pc_inc;
         end
         avm_pkg::OP_ST: begin
            if (r.io_is_message) o.message_request = 1'b1;
            else o.store_request = 1'b1;
            mach_pc = pc_inc;
         end
         avm_pkg::OP_LT: begin
            mach_acc = (mach_acc < mach_operand) ? 32'sd1 : 32'sd0;
            mach_pc = pc_inc;
         end
         avm_pkg::OP_GT: begin
            mach_acc = (mach_acc > mach_operand) ? 32'sd1 : 32'sd0;
            mach_pc = pc_inc;
         end
         avm_pkg::OP_LTE: begin
            mach_acc = (mach_acc <= mach_operand) ? 32'sd1 : 32'sd0;
            mach_pc = pc_inc;
         end
         avm_pkg::OP_GTE: begin
            mach_acc = (mach_acc >= mach_operand) ? 32'sd1 : 32'sd0;
            mach_pc = pc_inc;
         end
         avm_pkg::OP_EQI, avm_pkg::OP_EQ: begin
            mach_acc = (mach_acc == mach_operand) ? 32'sd1 : 32'sd0;
            mach_pc = pc_inc;
         end
         avm_pkg::OP_BZ:  mach_pc = (mach_acc == 0) ? r.immediate[7:0] : pc_inc;
         avm_pkg::OP_BNZ: mach_pc = (mach_acc != 0) ? r.immediate[7:0] : pc_inc;
         avm_pkg::OP_DLY: begin
            o.delay_request = 1'b1;
            mach_pc = pc_inc;
         end
         avm_pkg::OP_HALT: mach_halt = 1'b1;
         avm_pkg::OP_JMP:  mach_pc = r.immediate[7:0];
         avm_pkg::OP_ADDI, avm_pkg::OP_ADD: begin
            mach_acc = mach_acc + mach_operand;
            mach_pc = pc_inc;
         end
         avm_pkg::OP_SUBI, avm_pkg::OP_SUB: begin
            mach_acc = mach_acc - mach_operand;
            mach_pc = pc_inc;
         end
         avm_pkg::OP_RSV2, avm_pkg::OP_RSV4, avm_pkg::OP_RSV13: ;
         default: mach_halt = 1'b1;   // codes past the table halt, pc holds
      endcase
      o.next_pc = mach_pc;
      o.acc_out = mach_acc;
      o.halted = mach_halt;
      return o;
   endfunction

   // Small values make zero and equal compares common; extremes hit the wrap cases.
   function automatic logic signed [31:0] pick_word();
      logic signed [31:0] w;
      case ($urandom_range(0, 3))
         0: w = $signed($urandom_range(0, 8)) - 32'sd4;
         1: begin
            case ($urandom_range(0, 3))
               0: w = 32'h7FFF_FFFF;
               1: w = 32'h8000_0000;
               2: w = '0;
               default: w = '1;
            endcase
         end
         default: w = $urandom;
      endcase
      return w;
   endfunction

   task automatic add_instr(avm_pkg::opcode_type op, logic [31:0] imm, logic [31:0] io,
                            logic msg);
      avm_pkg::req_type r;
      r.opcode = op;
      r.immediate = imm;
      r.io_value = io;
      r.io_is_message = msg;
      instr_q.push_back(r);
   endtask

   // Halting codes are kept out until the last phase, since the flag never clears.
   task automatic add_random(int count, bit allow_halt);
      avm_pkg::opcode_type op;
      repeat (count) begin
         if (allow_halt) begin
            op = avm_pkg::opcode_type'($urandom_range(0, 31));
         end else begin
            do op = avm_pkg::opcode_type'($urandom_range(0, 21));
            while (op == avm_pkg::OP_HALT);
         end
         add_instr(op, pick_word(), pick_word(), 1'($urandom_range(0, 1)));
      end
   endtask

   // Wait until every queued instruction has its result back.
   task automatic drain();
      while (instr_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
         @(negedge clock);
   endtask

   // Sender: keep valid and payload stable until the beat is taken, then advance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_rsp_q.push_back(execute_instr(req_data));
         if (!req_valid || req_ready) begin
            if (instr_q.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 10)) begin
               req_valid <= 1'b1;
               req_data <= instr_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each result beat against the oldest prediction, then pick next ready.
   always @(posedge clock) begin
      avm_pkg::rsp_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("result beat with nothing expected: %p", rsp_data);
               mismatch_count++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               if (rsp_data.next_pc !== exp_rsp.next_pc) begin
                  $error("next_pc: expected %0d, got %0d", exp_rsp.next_pc, rsp_data.next_pc);
                  mismatch_count++;
               end
               if (rsp_data.acc_out !== exp_rsp.acc_out) begin
                  $error("acc_out: expected %0d, got %0d", exp_rsp.acc_out, rsp_data.acc_out);
                  mismatch_count++;
               end
               if (rsp_data.halted !== exp_rsp.halted) begin
                  $error("halted: expected %0b, got %0b", exp_rsp.halted, rsp_data.halted);
                  mismatch_count++;
               end
               if (rsp_data.store_request !== exp_rsp.store_request) begin
                  $error("store_request: expected %0b, got %0b",
                         exp_rsp.store_request, rsp_data.store_request);
                  mismatch_count++;
               end
               if (rsp_data.message_request !== exp_rsp.message_request) begin
                  $error("message_request: expected %0b, got %0b",
                         exp_rsp.message_request, rsp_data.message_request);
                  mismatch_count++;
               end
               if (rsp_data.delay_request !== exp_rsp.delay_request) begin
                  $error("delay_request: expected %0b, got %0b",
                         exp_rsp.delay_request, rsp_data.delay_request);
                  mismatch_count++;
               end
            end
         end
         // A new stall request starts a long hold-off so the pipeline backs up into req_.
         if (stall_token != stall_seen) begin
            stall_seen = stall_token;
            hold_left = HOLD_OFF;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (steady_flow) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 10);
         end
      end
   end

   // Watchdog: end the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL accumulator_vm_execute");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: signed extremes, wraparound, every compare, both branch outcomes,
      // store to a plain and to a message entry, delay, reserved codes, a far jump
      // target and pc wrapping past 255.
      add_instr(avm_pkg::OP_NOP,   32'h0,         32'h0,         1'b0);
      add_instr(avm_pkg::OP_LDI,   32'h7FFF_FFFF, 32'h0,         1'b0);
      add_instr(avm_pkg::OP_ADDI,  32'h1,         32'h0,         1'b0);   // wraps to the minimum
      add_instr(avm_pkg::OP_SUBI,  32'h1,         32'h0,         1'b0);   // wraps back
      add_instr(avm_pkg::OP_LD,    32'h0,         32'h8000_0000, 1'b1);
      add_instr(avm_pkg::OP_LT,    32'h0,         32'h7FFF_FFFF, 1'b0);
      add_instr(avm_pkg::OP_GT,    32'h0,         32'hFFFF_FFFF, 1'b0);
      add_instr(avm_pkg::OP_LTE,   32'h0,         32'h1,         1'b0);
      add_instr(avm_pkg::OP_GTE,   32'h0,         32'h2,         1'b0);
      add_instr(avm_pkg::OP_EQ,    32'h0,         32'h0,         1'b0);
      add_instr(avm_pkg::OP_EQI,   32'h5,         32'h0,         1'b0);
      add_instr(avm_pkg::OP_BZ,    32'hABCD_EF42, 32'h0,         1'b0);   // taken, far target
      add_instr(avm_pkg::OP_BNZ,   32'h7,         32'h0,         1'b0);   // not taken
      add_instr(avm_pkg::OP_ADD,   32'h0,         32'h7FFF_FFFF, 1'b0);
      add_instr(avm_pkg::OP_SUB,   32'h0,         32'h8000_0001, 1'b0);
      add_instr(avm_pkg::OP_ST,    32'h0,         32'h0,         1'b0);
      add_instr(avm_pkg::OP_ST,    32'h0,         32'h0,         1'b1);
      add_instr(avm_pkg::OP_DLY,   32'h3,         32'h0,         1'b0);
      add_instr(avm_pkg::OP_RSV2,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      add_instr(avm_pkg::OP_RSV4,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      add_instr(avm_pkg::OP_RSV13, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      add_instr(avm_pkg::OP_JMP,   32'hFFFF_FFFF, 32'h0,         1'b0);   // pc to 255
      add_instr(avm_pkg::OP_NOP,   32'h0,         32'h0,         1'b0);   // pc wraps to 0
      drain();

      // Full-rate stretch: no idling on either side.
      steady_flow = 1'b1;
      add_random(200, 1'b0);
      drain();
      steady_flow = 1'b0;

      // Random idling plus one long receiver hold-off while the sender keeps offering.
      stall_token++;
      add_random(150, 1'b0);
      drain();

      // Halt, then keep executing: the flag must stay set while everything else runs on.
      add_instr(avm_pkg::OP_HALT, pick_word(), pick_word(), 1'b0);
      add_instr(OP_PAST_TABLE,    pick_word(), pick_word(), 1'b1);
      add_instr(OP_TOP_CODE,      pick_word(), pick_word(), 1'b0);
      add_random(100, 1'b1);
      drain();

      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("PASS accumulator_vm_execute");
      end else begin
         $display("FAIL accumulator_vm_execute");
      end
      $finish;
   end

endmodule
